// ----- src/spq_pkg.sv -----
// Package for the sorted priority queue.
// Holds shared defaults, request and status codes, and the cell control struct.
// No dependencies.
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int PRIO_BITS_DEFAULT = 8;
    localparam int DATA_W            = 32;
    localparam int PRIO_IN_W         = 8;
    localparam int COUNT_OUT_W       = 5;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic push;   // insert the new entry (queue not full)
        logic pop;    // shift every entry one cell toward the head
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- src/spq_cell.sv -----
// One storage cell of the sorted chain: a data word and a priority.
// Depends on spq_pkg.
`default_nettype none

module spq_cell #(
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEFAULT
) (
    input  wire                            i_clk,
    input  wire spq_pkg::t_cell_ctrl       i_ctrl,
    input  wire                            i_occupied,
    input  wire  [spq_pkg::DATA_W-1:0]     i_new_data,
    input  wire  [PRIO_BITS-1:0]           i_new_prio,
    // neighbor toward the head
    input  wire                            i_left_ge,
    input  wire  [spq_pkg::DATA_W-1:0]     i_left_data,
    input  wire  [PRIO_BITS-1:0]           i_left_prio,
    // neighbor toward the tail
    input  wire  [spq_pkg::DATA_W-1:0]     i_right_data,
    input  wire  [PRIO_BITS-1:0]           i_right_prio,
    output logic                           o_ge,
    output logic [spq_pkg::DATA_W-1:0]     o_data,
    output logic [PRIO_BITS-1:0]           o_prio,
    output logic [spq_pkg::DATA_W-1:0]     o_next_data
);

    logic [spq_pkg::DATA_W-1:0] r_data;
    logic [spq_pkg::DATA_W-1:0] n_data;
    logic [PRIO_BITS-1:0]       r_prio;
    logic [PRIO_BITS-1:0]       n_prio;

    // New entry belongs at or ahead of this cell.
    assign o_ge = !i_occupied || (r_prio >= i_new_prio);

    always_comb begin
        n_data = r_data;
        n_prio = r_prio;
        if (i_ctrl.push) begin
            if (i_left_ge) begin
                n_data = i_left_data;
                n_prio = i_left_prio;
            end else if (o_ge) begin
                n_data = i_new_data;
                n_prio = i_new_prio;
            end
        end else if (i_ctrl.pop) begin
            n_data = i_right_data;
            n_prio = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_prio <= n_prio;
    end

    assign o_data      = r_data;
    assign o_prio      = r_prio;
    assign o_next_data = n_data;

endmodule

`default_nettype wire

// ----- src/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: a chain of spq_cell plus count
// and result register. Depends on spq_pkg and spq_cell.
`default_nettype none

// Sorted priority queue. Holds up to DEPTH entries (32-bit data plus a
// PRIO_BITS priority) in a row of cells kept in ascending priority order, the
// head in cell 0. A push compares its priority against all cells at once
// and each cell either keeps its entry, takes the new one or takes its
// head-side neighbor's; a pop shifts every cell one place toward the head.
// A request is taken every cycle while the result register is free or being
// drained, so the sustained rate is one request per cycle, and the result is
// registered and appears in the cycle after acceptance. Each request yields
// one result with the new head data (0 when empty), head valid, status (ok,
// pop on empty, push on full dropped) and the entry count. Priority bits above
// PRIO_BITS are ignored; the entry count output carries the low five bits.

module sorted_priority_queue #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEFAULT,
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEFAULT
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // request channel
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire                                 i_req_type,
    input  wire  signed [spq_pkg::DATA_W-1:0]   i_data_in,
    input  wire  [spq_pkg::PRIO_IN_W-1:0]       i_priority_in,
    // result channel
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic signed [spq_pkg::DATA_W-1:0]   o_head_data,
    output logic                                o_head_valid,
    output logic [1:0]                          o_status,
    output logic [spq_pkg::COUNT_OUT_W-1:0]     o_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                        accept;
    logic                        is_pop;
    logic                        full;
    logic                        empty;
    logic [PRIO_BITS-1:0]        new_prio;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    spq_pkg::t_cell_ctrl         ctrl;
    spq_pkg::t_status            status;

    // chain wiring
    logic                        cell_ge   [DEPTH];
    logic [spq_pkg::DATA_W-1:0]  cell_data [DEPTH];
    logic [PRIO_BITS-1:0]        cell_prio [DEPTH];
    logic [spq_pkg::DATA_W-1:0]  cell_next [DEPTH];

    // result register
    logic                        r_out_valid;
    logic [spq_pkg::DATA_W-1:0]  r_head_data;
    logic                        r_head_valid;
    spq_pkg::t_status            r_status;
    logic [CW-1:0]               r_out_count;

    // Result register frees up when empty or drained this cycle.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign is_pop   = (spq_pkg::t_req'(i_req_type) == spq_pkg::REQ_POP);
    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);
    // truncates or zero-extends to the configured priority width
    assign new_prio = PRIO_BITS'(i_priority_in);

    always_comb begin
        ctrl.push = 1'b0;
        ctrl.pop  = 1'b0;
        status    = spq_pkg::ST_OK;
        n_count   = r_count;
        if (accept) begin
            if (is_pop) begin
                if (empty) begin
                    status = spq_pkg::ST_POP_EMPTY;
                end else begin
                    ctrl.pop = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end else begin
                if (full) begin
                    status = spq_pkg::ST_PUSH_FULL;
                end else begin
                    ctrl.push = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                       left_ge;
            logic [spq_pkg::DATA_W-1:0] left_data;
            logic [PRIO_BITS-1:0]       left_prio;
            logic [spq_pkg::DATA_W-1:0] right_data;
            logic [PRIO_BITS-1:0]       right_prio;

            if (gi == 0) begin : g_head
                assign left_ge   = 1'b0;
                assign left_data = '0;
                assign left_prio = '0;
            end else begin : g_mid
                assign left_ge   = cell_ge[gi-1];
                assign left_data = cell_data[gi-1];
                assign left_prio = cell_prio[gi-1];
            end

            // tail cell keeps its contents on pop; it falls out of the count
            if (gi == DEPTH - 1) begin : g_tail
                assign right_data = cell_data[gi];
                assign right_prio = cell_prio[gi];
            end else begin : g_body
                assign right_data = cell_data[gi+1];
                assign right_prio = cell_prio[gi+1];
            end

            spq_cell #(
                .PRIO_BITS (PRIO_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (ctrl),
                .i_occupied   (r_count > CW'(gi)),
                .i_new_data   (i_data_in),
                .i_new_prio   (new_prio),
                .i_left_ge    (left_ge),
                .i_left_data  (left_data),
                .i_left_prio  (left_prio),
                .i_right_data (right_data),
                .i_right_prio (right_prio),
                .o_ge         (cell_ge[gi]),
                .o_data       (cell_data[gi]),
                .o_prio       (cell_prio[gi]),
                .o_next_data  (cell_next[gi])
            );
        end
    endgenerate

    // count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, shows the queue after the request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_head_data  <= (n_count != '0) ? cell_next[0] : '0;
            r_head_valid <= (n_count != '0);
            r_status     <= status;
            r_out_count  <= n_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_head_data   = r_head_data;
    assign o_head_valid  = r_head_valid;
    assign o_status      = r_status;
    assign o_entry_count = spq_pkg::COUNT_OUT_W'(r_out_count);

endmodule

`default_nettype wire
